// ----- rtl/core/absmax_int8_group_quantizer_defines.svh -----
// Assertion macros used by the group quantizer top level.
`ifndef ABSMAX_INT8_GROUP_QUANTIZER_DEFINES_SVH
`define ABSMAX_INT8_GROUP_QUANTIZER_DEFINES_SVH

// Same-cycle implication, checked on i_clk and masked while i_rst_n is low.
`define AGQ_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on i_clk and masked while i_rst_n is low.
`define AGQ_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/agq_pkg.sv -----
// Types and constants of the absmax int8 group quantizer.
package agq_pkg;

    localparam int ValueBitsDef = 32;
    localparam int AmaxW        = 32;
    localparam int RecipW       = 48;
    localparam int RecipNumW    = 47;
    localparam int RecipHalfW   = 24;
    localparam int RoundPos     = 39;

    localparam logic [AmaxW-1:0]     OneRaw    = 32'd65536;
    localparam logic [RecipNumW-1:0] RecipNum  = 47'd127 << 40;
    localparam logic [RecipW-1:0]    RecipOne  = 48'd127 << 24;
    localparam logic [6:0]           QMax      = 7'd127;

    localparam logic KindScan  = 1'b0;
    localparam logic KindQuant = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

// ----- rtl/core/agq_div.sv -----
// Restoring divider that forms the group reciprocal, one quotient bit per cycle.
module agq_div
    import agq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [AmaxW-1:0]     i_divisor,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [RecipNumW-1:0] o_quot
);

    localparam int CntW = $clog2(RecipNumW);

    logic                 r_busy;
    logic                 r_done;
    logic [CntW-1:0]      r_cnt;
    logic [AmaxW-1:0]     r_div;
    logic [AmaxW-1:0]     r_rem;
    logic [RecipNumW-1:0] r_quot;

    logic [AmaxW:0]       trial;
    logic [AmaxW+1:0]     diff;
    logic                 ge;

    always_comb begin
        trial = {r_rem, RecipNum[r_cnt]};
        diff  = {1'b0, trial} - {2'b00, r_div};
        ge    = !diff[AmaxW+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_cnt == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cnt  <= CntW'(RecipNumW - 1);
            r_div  <= i_divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_cnt  <= r_cnt - 1'b1;
            r_rem  <= ge ? diff[AmaxW-1:0] : trial[AmaxW-1:0];
            r_quot <= {r_quot[RecipNumW-2:0], ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/core/absmax_int8_group_quantizer.sv -----
// Top level of the symmetric absmax int8 group quantizer.
//
//   Channel   Direction  Handshake           Beat
//   input     in         i_valid / o_stall   i_kind, i_sample, i_last
//   output    out        o_valid / i_stall   o_quant, o_group_max, o_is_scale
//
// A scan beat that does not close a group only updates the running maximum; the controller stays idle.
// A quantize beat passes through ST_MUL_LO, ST_MUL_HI and ST_EMIT; one 32 by 24 bit multiplier is used twice.
// A closing scan beat waits in ST_DIV for the bit-serial reciprocal divider.
// The result sits in an output register, so a new beat is taken while it waits.
// Reset is synchronous; the group maximum clears and the reciprocal returns to that of 1.0.
`include "absmax_int8_group_quantizer_defines.svh"

module absmax_int8_group_quantizer
    import agq_pkg::*;
#(
    parameter int VALUE_BITS = ValueBitsDef
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_kind,
    input  logic signed [31:0] i_sample,
    input  logic               i_last,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [7:0]  o_quant,
    output logic [AmaxW-1:0]   o_group_max,
    output logic               o_is_scale
);

    localparam int ProdW = VALUE_BITS + RecipHalfW;
    localparam int SumW  = ProdW + 1;

    t_state r_state;
    t_state n_state;

    logic [VALUE_BITS-1:0] r_run_max;
    logic [RecipW-1:0]     r_recip;
    logic [VALUE_BITS-1:0] r_mag;
    logic                  r_neg;
    logic                  r_is_scale;
    logic [AmaxW-1:0]      r_amax;
    logic [SumW-1:0]       r_part;
    logic signed [7:0]     r_res_quant;
    logic                  r_o_valid;
    logic signed [7:0]     r_o_quant;
    logic [AmaxW-1:0]      r_o_group_max;
    logic                  r_o_is_scale;

    logic [VALUE_BITS-1:0] raw;
    logic                  neg;
    logic [VALUE_BITS-1:0] mag;
    logic [VALUE_BITS-1:0] new_max;
    logic [AmaxW-1:0]      amax;
    logic [RecipHalfW-1:0] mul_b;
    logic [ProdW-1:0]      prod;
    logic [SumW-1:0]       sum;
    logic                  sat;
    logic [6:0]            q_mag;
    logic signed [7:0]     q_signed;
    logic                  in_acc;
    logic                  div_start;
    logic                  out_load;
    logic                  div_busy;
    logic                  div_done;
    logic [RecipNumW-1:0]  div_quot;

    always_comb begin
        raw     = i_sample[VALUE_BITS-1:0];
        neg     = raw[VALUE_BITS-1];
        mag     = neg ? (~raw + 1'b1) : raw;
        new_max = (mag > r_run_max) ? mag : r_run_max;
        amax    = (new_max == '0) ? OneRaw : AmaxW'(new_max);
    end

    always_comb begin
        mul_b    = (r_state == ST_MUL_LO) ? r_recip[RecipHalfW-1:0]
                                          : r_recip[RecipW-1:RecipHalfW];
        prod     = r_mag * mul_b;
        sum      = SumW'(prod) + SumW'(r_part >> RecipHalfW);
        sat      = |sum[SumW-1:23];
        q_mag    = sat ? QMax : sum[22:16];
        q_signed = r_neg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    end

    agq_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_divisor (amax),
        .o_busy    (div_busy),
        .o_done    (div_done),
        .o_quot    (div_quot)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_kind == KindQuant) begin
                        n_state = ST_MUL_LO;
                    end else if (i_last) begin
                        n_state = ST_DIV;
                    end
                end
            end
            ST_MUL_LO: begin
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                n_state = ST_EMIT;
            end
            ST_DIV: begin
                if (div_done) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        in_acc    = i_valid && (r_state == ST_IDLE);
        div_start = in_acc && (i_kind == KindScan) && i_last;
        out_load  = (r_state == ST_EMIT) && (!r_o_valid || !i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_run_max <= '0;
            r_recip   <= RecipOne;
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_acc && (i_kind == KindScan)) begin
                r_run_max <= i_last ? '0 : new_max;
            end
            if ((r_state == ST_DIV) && div_done) begin
                r_recip <= RecipW'(div_quot);
            end
            r_o_valid <= out_load || (r_o_valid && i_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_mag      <= mag;
            r_neg      <= neg;
            r_is_scale <= (i_kind == KindScan);
            r_amax     <= amax;
        end
        if (r_state == ST_MUL_LO) begin
            r_part <= SumW'(prod) + (SumW'(1) << RoundPos);
        end
        if (r_state == ST_MUL_HI) begin
            r_res_quant <= q_signed;
        end
        if (out_load) begin
            r_o_quant     <= r_is_scale ? '0 : r_res_quant;
            r_o_group_max <= r_is_scale ? r_amax : '0;
            r_o_is_scale  <= r_is_scale;
        end
    end

    assign o_stall     = (r_state != ST_IDLE);
    assign o_valid     = r_o_valid;
    assign o_quant     = r_o_quant;
    assign o_group_max = r_o_group_max;
    assign o_is_scale  = r_o_is_scale;

    `AGQ_ASSERT_IMP(a_scale_beat_shape, r_o_valid && r_o_is_scale,
        r_o_quant == '0 && r_o_group_max != '0, "Scale beat carries a quantized value.")
    `AGQ_ASSERT_IMP(a_quant_beat_shape, r_o_valid && !r_o_is_scale,
        r_o_quant != 8'sh80 && r_o_group_max == '0, "Quantized beat out of range.")
    `AGQ_ASSERT_IMP(a_div_owned, r_state != ST_DIV, !div_busy,
        "Divider busy outside the division state.")
    `AGQ_ASSERT_NXT(a_max_cleared, div_start, r_run_max == '0,
        "Group maximum not cleared at the close of a group.")
    `AGQ_ASSERT_IMP(a_recip_nonzero, r_state == ST_MUL_LO, r_recip != '0,
        "Reciprocal is zero during quantization.")

endmodule
